/* sv/mi4_pkg.sv */
// Package for the 4x4 adjugate matrix inverse block.
// Holds shared constants, types, the command and status structs and the minor step tables.
// No dependencies.
package mi4_pkg;

	// Default widths of the external fixed-point format.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Internal arithmetic: 64-bit signed values held to a 62-bit magnitude.
	localparam int IW = 64;
	localparam int MAG_W = 62;
	localparam logic signed [IW-1:0] ILIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	// Output modes of the configuration register.
	typedef enum logic [1:0] {
		MODE_INV  = 2'd0,
		MODE_INVT = 2'd1,
		MODE_COF  = 2'd2,
		MODE_TR   = 2'd3
	} mode_t;

	// Source of the second multiplier operand.
	typedef enum logic [1:0] {
		BSEL_MAT = 2'd0,
		BSEL_T   = 2'd1,
		BSEL_COF = 2'd2
	} bsel_t;

	// What happens to the accumulator after a product step.
	typedef enum logic [1:0] {
		POST_NONE = 2'd0,
		POST_T    = 2'd1,
		POST_COF  = 2'd2,
		POST_DET  = 2'd3
	} post_t;

	// One product step of a 3x3 minor determinant.
	typedef struct packed {
		logic [3:0] a_n;
		logic       b_t;
		logic [3:0] b_n;
		logic       sub;
		logic       clear;
		post_t      post;
		logic [1:0] t_idx;
	} step_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_en;
		logic [3:0] ld_addr;
		logic [3:0] m_addr;
		logic [3:0] c_addr;
		logic       opa_load;
		logic       mul_start;
		bsel_t      bsel;
		logic [1:0] t_rd;
		logic       acc_clear;
		logic       acc_sub;
		logic       clip_clear;
		post_t      post;
		logic [1:0] t_wr;
		logic       cof_neg;
		logic [3:0] wr_idx;
		logic       res_load;
		mode_t      mode;
		logic       div_start;
		logic       out_load;
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic singular;
		logic out_free;
	} sts_t;

	// Step table of a 3x3 determinant: three 2x2 terms, then the first-row expansion.
	function automatic step_t det3_step(input logic [3:0] s);
		step_t st;
		begin
			st = '0;
			unique case (s)
				4'd0: begin st.a_n = 4'd4; st.b_n = 4'd8; st.clear = 1'b1; end
				4'd1: begin
					st.a_n = 4'd5; st.b_n = 4'd7; st.sub = 1'b1;
					st.post = POST_T; st.t_idx = 2'd0;
				end
				4'd2: begin st.a_n = 4'd3; st.b_n = 4'd8; st.clear = 1'b1; end
				4'd3: begin
					st.a_n = 4'd5; st.b_n = 4'd6; st.sub = 1'b1;
					st.post = POST_T; st.t_idx = 2'd1;
				end
				4'd4: begin st.a_n = 4'd3; st.b_n = 4'd7; st.clear = 1'b1; end
				4'd5: begin
					st.a_n = 4'd4; st.b_n = 4'd6; st.sub = 1'b1;
					st.post = POST_T; st.t_idx = 2'd2;
				end
				4'd6: begin st.a_n = 4'd0; st.b_t = 1'b1; st.b_n = 4'd0; st.clear = 1'b1; end
				4'd7: begin st.a_n = 4'd1; st.b_t = 1'b1; st.b_n = 4'd1; st.sub = 1'b1; end
				4'd8: begin
					st.a_n = 4'd2; st.b_t = 1'b1; st.b_n = 4'd2; st.post = POST_COF;
				end
				default: st = '0;
			endcase
			return st;
		end
	endfunction

	// Address in the 4x4 store of element n of the minor that drops row r and column c.
	function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
			input logic [3:0] n);
		logic [1:0] mr;
		logic [1:0] mc;
		logic [1:0] i;
		logic [1:0] j;
		begin
			unique case (n)
				4'd0: begin mr = 2'd0; mc = 2'd0; end
				4'd1: begin mr = 2'd0; mc = 2'd1; end
				4'd2: begin mr = 2'd0; mc = 2'd2; end
				4'd3: begin mr = 2'd1; mc = 2'd0; end
				4'd4: begin mr = 2'd1; mc = 2'd1; end
				4'd5: begin mr = 2'd1; mc = 2'd2; end
				4'd6: begin mr = 2'd2; mc = 2'd0; end
				4'd7: begin mr = 2'd2; mc = 2'd1; end
				4'd8: begin mr = 2'd2; mc = 2'd2; end
				default: begin mr = 2'd0; mc = 2'd0; end
			endcase
			i = (mr >= r) ? 2'(mr + 2'd1) : mr;
			j = (mc >= c) ? 2'(mc + 2'd1) : mc;
			return {i, j};
		end
	endfunction

endpackage

/* sv/matrix4_inverse_adjugate_top.sv */
// 4x4 matrix inverse by the adjugate: accepts 16 elements, one beat per cycle, then is busy.
// After the 16th element the shared multiplier forms 148 products, then each result is read
// and, in the inverse modes, divided by the determinant in the bit-serial divider.
// A new matrix is taken only after the last result of the run has gone into the output register.
// Asynchronous active-low reset clears the load count, state machine and mode register (inverse).
module matrix4_inverse_adjugate_top #(
	parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] element,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   output_mode,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic [1:0]                   out_row,
	output logic [1:0]                   out_col,
	output logic signed [DATA_WIDTH-1:0] det_value,
	output logic                         singular,
	output logic                         saturated,
	output logic                         last
);

	mi4_pkg::cmd_t cmd;
	mi4_pkg::sts_t sts;

	// Sequencing.
	mi4_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.output_mode(output_mode),
		.cmd(cmd),
		.sts(sts)
	);

	// Arithmetic and storage.
	mi4_dp #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.element(element),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.value(value),
		.out_row(out_row),
		.out_col(out_col),
		.det_value(det_value),
		.singular(singular),
		.saturated(saturated),
		.last(last)
	);

endmodule

/* sv/mi4_mul.sv */
// Multi-cycle fixed-point multiplier: four 31x31 partial products, then rounding.
// Result is rounded half away from zero and held to the 62-bit internal magnitude.
// Depends on mi4_pkg.
module mi4_mul #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [mi4_pkg::IW-1:0]     a,
	input  logic signed [mi4_pkg::IW-1:0]     b,
	output logic                              done,
	output logic signed [mi4_pkg::IW-1:0]     res,
	output logic                              clip
);

	localparam int PW = 2 * mi4_pkg::MAG_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	logic [mi4_pkg::MAG_W-1:0] am_q;
	logic [mi4_pkg::MAG_W-1:0] bm_q;
	logic                      neg_q;
	logic [1:0]                cnt_q;
	logic                      busy_q;
	logic                      rnd_q;
	logic                      done_q;
	logic [PW-1:0]             acc_q;
	logic signed [mi4_pkg::IW-1:0] res_q;
	logic                      clip_q;

	logic [mi4_pkg::IW-1:0] a_abs;
	logic [mi4_pkg::IW-1:0] b_abs;
	logic [30:0]            a_part;
	logic [30:0]            b_part;
	logic [61:0]            pp;
	logic [PW-1:0]          pp_sh;
	logic [PW-1:0]          rounded;
	logic [PW-1:0]          shifted;
	logic                   rclip;
	logic [mi4_pkg::MAG_W-1:0] rmag;

	// Operand magnitudes.
	assign a_abs = a[mi4_pkg::IW-1] ? 64'(-a) : 64'(a);
	assign b_abs = b[mi4_pkg::IW-1] ? 64'(-b) : 64'(b);

	// Partial product selected by the step counter and aligned to its weight.
	always_comb begin
		a_part = cnt_q[1] ? am_q[61:31] : am_q[30:0];
		b_part = cnt_q[0] ? bm_q[61:31] : bm_q[30:0];
		pp = a_part * b_part;
		case (cnt_q)
			2'd0: pp_sh = PW'(pp);
			2'd1: pp_sh = PW'(pp) << 31;
			2'd2: pp_sh = PW'(pp) << 31;
			default: pp_sh = PW'(pp) << 62;
		endcase
	end

	// Rounding, scaling and magnitude limit.
	always_comb begin
		rounded = acc_q + HALF;
		shifted = rounded >> FRAC_BITS;
		rclip = |shifted[PW-1:mi4_pkg::MAG_W];
		rmag = rclip ? '1 : shifted[mi4_pkg::MAG_W-1:0];
	end

	// Sequencing of the partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= 2'(cnt_q + 2'd1);
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a_abs[mi4_pkg::MAG_W-1:0];
			bm_q  <= b_abs[mi4_pkg::MAG_W-1:0];
			neg_q <= a[mi4_pkg::IW-1] ^ b[mi4_pkg::IW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (rnd_q) begin
			res_q  <= neg_q ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
			clip_q <= rclip;
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule

/* sv/mi4_div.sv */
// Restoring fixed-point divider, one quotient bit per cycle.
// Quotient is |n|*2^FRAC_BITS/|d| rounded half away from zero, held to the internal magnitude.
// Depends on mi4_pkg.
module mi4_div #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [mi4_pkg::IW-1:0] n,
	input  logic signed [mi4_pkg::IW-1:0] d,
	output logic                          done,
	output logic signed [mi4_pkg::IW-1:0] res,
	output logic                          clip
);

	localparam int NW = mi4_pkg::MAG_W + 1 + FRAC_BITS;
	localparam int CW = $clog2(NW);
	localparam int RW = mi4_pkg::MAG_W + 1;

	logic [NW-1:0]             num_q;
	logic [NW-1:0]             quo_q;
	logic [RW-1:0]             rem_q;
	logic [mi4_pkg::MAG_W-1:0] dm_q;
	logic                      neg_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      fin_q;
	logic                      done_q;
	logic signed [mi4_pkg::IW-1:0] res_q;
	logic                      clip_q;

	logic [mi4_pkg::IW-1:0] n_abs;
	logic [mi4_pkg::IW-1:0] d_abs;
	logic [NW-1:0]          num_init;
	logic [RW-1:0]          rem_sh;
	logic                   qbit;
	logic [RW-1:0]          rem_nx;
	logic                   fclip;
	logic [mi4_pkg::MAG_W-1:0] fmag;

	// Operand magnitudes and the rounded, scaled dividend.
	always_comb begin
		n_abs = n[mi4_pkg::IW-1] ? 64'(-n) : 64'(n);
		d_abs = d[mi4_pkg::IW-1] ? 64'(-d) : 64'(d);
		num_init = NW'({n_abs[mi4_pkg::MAG_W-1:0], {FRAC_BITS{1'b0}}})
			+ NW'(d_abs[mi4_pkg::MAG_W-1:1]);
	end

	// One restoring step.
	always_comb begin
		rem_sh = {rem_q[RW-2:0], num_q[NW-1]};
		qbit = rem_sh >= {1'b0, dm_q};
		rem_nx = qbit ? RW'(rem_sh - {1'b0, dm_q}) : rem_sh;
	end

	// Magnitude limit of the final quotient.
	always_comb begin
		fclip = |quo_q[NW-1:mi4_pkg::MAG_W];
		fmag = fclip ? '1 : quo_q[mi4_pkg::MAG_W-1:0];
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= CW'(cnt_q - 1'b1);
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Dividend, remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_init;
			quo_q <= '0;
			rem_q <= '0;
			dm_q  <= d_abs[mi4_pkg::MAG_W-1:0];
			neg_q <= n[mi4_pkg::IW-1] ^ d[mi4_pkg::IW-1];
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], qbit};
			rem_q <= rem_nx;
		end
		if (fin_q) begin
			res_q  <= neg_q ? -$signed({2'b00, fmag}) : $signed({2'b00, fmag});
			clip_q <= fclip;
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule

/* sv/mi4_dp.sv */
// Datapath of the 4x4 adjugate inverse: element store, cofactor store, accumulator,
// output register, and the shared multiplier and divider.
// Depends on mi4_pkg, mi4_mul and mi4_div.
module mi4_dp #(
	parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mi4_pkg::cmd_t                cmd,
	output mi4_pkg::sts_t                sts,
	input  logic signed [DATA_WIDTH-1:0] element,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic [1:0]                   out_row,
	output logic [1:0]                   out_col,
	output logic signed [DATA_WIDTH-1:0] det_value,
	output logic                         singular,
	output logic                         saturated,
	output logic                         last
);

	localparam int IW = mi4_pkg::IW;
	localparam logic signed [IW-1:0] OMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [IW-1:0] OMIN = -OMAX - 64'sd1;
	localparam logic signed [IW:0] LIM_HI = {1'b0, mi4_pkg::ILIM};
	localparam logic signed [IW:0] LIM_LO = -LIM_HI;

	// Stores.
	logic signed [DATA_WIDTH-1:0] mstore [16];
	logic signed [IW-1:0]         cstore [16];
	logic [15:0]                  cclip_q;
	logic signed [DATA_WIDTH-1:0] mrd_q;
	logic signed [IW-1:0]         crd_q;
	logic                         crclip_q;

	// Working registers.
	logic signed [IW-1:0] opa_q;
	logic signed [IW-1:0] t_q [3];
	logic signed [IW-1:0] acc_q;
	logic                 clip_q;
	logic signed [IW-1:0] det_q;
	logic                 singular_q;
	logic signed [DATA_WIDTH-1:0] dout_q;
	logic                 dclip_q;
	logic signed [IW-1:0] res_q;
	logic                 rclip_q;

	// Output register.
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic [1:0]                   row_q;
	logic [1:0]                   col_q;
	logic signed [DATA_WIDTH-1:0] det_value_q;
	logic                         singular_out_q;
	logic                         saturated_q;
	logic                         last_q;

	// Units.
	logic signed [IW-1:0] mrd_ext;
	logic signed [IW-1:0] opb;
	logic                 mul_done;
	logic signed [IW-1:0] mul_res;
	logic                 mul_clip;
	logic                 div_done;
	logic signed [IW-1:0] div_res;
	logic                 div_clip;

	logic signed [IW:0]   base;
	logic signed [IW:0]   sum;
	logic signed [IW-1:0] acc_nx;
	logic                 acc_clip;
	logic signed [IW-1:0] cof_val;
	logic [DATA_WIDTH:0]  det_sat;
	logic [DATA_WIDTH:0]  res_sat;

	// Saturation of an internal value to the external width; bit DATA_WIDTH flags a clip.
	function automatic logic [DATA_WIDTH:0] sat_out(input logic signed [IW-1:0] v);
		begin
			if (v > OMAX) begin
				return {1'b1, OMAX[DATA_WIDTH-1:0]};
			end else if (v < OMIN) begin
				return {1'b1, OMIN[DATA_WIDTH-1:0]};
			end else begin
				return {1'b0, v[DATA_WIDTH-1:0]};
			end
		end
	endfunction

	assign mrd_ext = {{(IW - DATA_WIDTH){mrd_q[DATA_WIDTH-1]}}, mrd_q};

	// Second multiplier operand.
	always_comb begin
		case (cmd.bsel)
			mi4_pkg::BSEL_MAT: opb = mrd_ext;
			mi4_pkg::BSEL_T:   opb = t_q[cmd.t_rd];
			mi4_pkg::BSEL_COF: opb = crd_q;
			default:           opb = '0;
		endcase
	end

	mi4_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mul_start),
		.a(opa_q),
		.b(opb),
		.done(mul_done),
		.res(mul_res),
		.clip(mul_clip)
	);

	mi4_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.n(crd_q),
		.d(det_q),
		.done(div_done),
		.res(div_res),
		.clip(div_clip)
	);

	// Accumulate one rounded product and hold the sum to the internal limit.
	always_comb begin
		base = cmd.acc_clear ? '0 : {acc_q[IW-1], acc_q};
		sum = cmd.acc_sub ? base - {mul_res[IW-1], mul_res} : base + {mul_res[IW-1], mul_res};
		acc_clip = 1'b0;
		if (sum > LIM_HI) begin
			acc_nx = mi4_pkg::ILIM;
			acc_clip = 1'b1;
		end else if (sum < LIM_LO) begin
			acc_nx = -mi4_pkg::ILIM;
			acc_clip = 1'b1;
		end else begin
			acc_nx = sum[IW-1:0];
		end
	end

	assign cof_val = cmd.cof_neg ? -acc_q : acc_q;
	assign det_sat = sat_out(acc_q);
	assign res_sat = sat_out(res_q);

	// Element and cofactor stores with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			mstore[cmd.ld_addr] <= element;
		end
		if (cmd.post == mi4_pkg::POST_COF) begin
			cstore[cmd.wr_idx]  <= cof_val;
			cclip_q[cmd.wr_idx] <= clip_q;
		end
		mrd_q    <= mstore[cmd.m_addr];
		crd_q    <= cstore[cmd.c_addr];
		crclip_q <= cclip_q[cmd.c_addr];
	end

	// Accumulator, minor terms, determinant and result value.
	always_ff @(posedge clk) begin
		if (cmd.opa_load) begin
			opa_q <= mrd_ext;
		end
		if (mul_done) begin
			acc_q  <= acc_nx;
			clip_q <= (cmd.clip_clear ? 1'b0 : clip_q) | mul_clip | acc_clip;
		end
		if (cmd.post == mi4_pkg::POST_T) begin
			t_q[cmd.t_wr] <= acc_q;
		end
		if (cmd.post == mi4_pkg::POST_DET) begin
			det_q      <= acc_q;
			singular_q <= acc_q == '0;
			dout_q     <= det_sat[DATA_WIDTH-1:0];
			dclip_q    <= clip_q | det_sat[DATA_WIDTH];
		end
		if (cmd.res_load) begin
			case (cmd.mode) inside
				mi4_pkg::MODE_INV, mi4_pkg::MODE_INVT: begin
					res_q   <= '0;
					rclip_q <= singular_q ? 1'b0 : crclip_q;
				end
				mi4_pkg::MODE_COF: begin
					res_q   <= crd_q;
					rclip_q <= crclip_q;
				end
				default: begin
					res_q   <= mrd_ext;
					rclip_q <= 1'b0;
				end
			endcase
		end else if (div_done) begin
			res_q   <= div_res;
			rclip_q <= rclip_q | div_clip;
		end
	end

	// Output register: the valid flag is control, the payload is not reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q        <= res_sat[DATA_WIDTH-1:0];
			row_q          <= cmd.row;
			col_q          <= cmd.col;
			det_value_q    <= dout_q;
			singular_out_q <= singular_q;
			saturated_q    <= rclip_q | res_sat[DATA_WIDTH] | dclip_q;
			last_q         <= cmd.last;
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.singular = singular_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign det_value = det_value_q;
	assign singular  = singular_out_q;
	assign saturated = saturated_q;
	assign last      = last_q;

endmodule

/* sv/mi4_ctrl.sv */
// Controller of the 4x4 adjugate inverse: load counter, cofactor and determinant
// sequencing, output sequencing and the mode register.
// Depends on mi4_pkg.
module mi4_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    output_mode,
	output mi4_pkg::cmd_t cmd,
	input  mi4_pkg::sts_t sts
);

	typedef enum logic [9:0] {
		S_LOAD  = 10'b00_0000_0001,
		S_RDA   = 10'b00_0000_0010,
		S_RDB   = 10'b00_0000_0100,
		S_MGO   = 10'b00_0000_1000,
		S_MWAIT = 10'b00_0001_0000,
		S_POST  = 10'b00_0010_0000,
		S_ORD   = 10'b00_0100_0000,
		S_OGO   = 10'b00_1000_0000,
		S_ODIV  = 10'b01_0000_0000,
		S_OPUT  = 10'b10_0000_0000
	} state_t;

	state_t         state_q;
	logic [3:0]     ld_cnt_q;
	logic [3:0]     k_q;
	logic [3:0]     step_q;
	logic           det_ph_q;
	mi4_pkg::mode_t cfg_mode_q;
	mi4_pkg::mode_t run_mode_q;

	logic [1:0]    r;
	logic [1:0]    c;
	mi4_pkg::step_t st;
	logic [3:0]    a_addr;
	logic [3:0]    b_addr;
	logic [3:0]    src_tr;
	logic          need_div;
	logic          in_acc;

	assign in_acc    = in_valid && (state_q == S_LOAD);
	assign in_stall  = state_q != S_LOAD;
	assign cfg_ready = 1'b1;

	// Operand addresses of the current product step.
	always_comb begin
		r = k_q[3:2];
		c = k_q[1:0];
		st = mi4_pkg::det3_step(step_q);
		src_tr = {c, r};
		if (det_ph_q) begin
			a_addr = {2'b00, step_q[1:0]};
			b_addr = {2'b00, step_q[1:0]};
		end else begin
			a_addr = mi4_pkg::minor_addr(r, c, st.a_n);
			b_addr = mi4_pkg::minor_addr(r, c, st.b_n);
		end
		need_div = (run_mode_q == mi4_pkg::MODE_INV || run_mode_q == mi4_pkg::MODE_INVT)
			&& !sts.singular;
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.ld_addr    = ld_cnt_q;
		cmd.bsel       = det_ph_q ? mi4_pkg::BSEL_COF
			: (st.b_t ? mi4_pkg::BSEL_T : mi4_pkg::BSEL_MAT);
		cmd.t_rd       = st.b_n[1:0];
		cmd.acc_clear  = det_ph_q ? (step_q == 4'd0) : st.clear;
		cmd.acc_sub    = det_ph_q ? 1'b0 : st.sub;
		cmd.clip_clear = step_q == 4'd0;
		cmd.t_wr       = st.t_idx;
		cmd.cof_neg    = k_q[2] ^ k_q[0];
		cmd.wr_idx     = k_q;
		cmd.mode       = run_mode_q;
		cmd.row        = r;
		cmd.col        = c;
		cmd.last       = k_q == 4'd15;
		unique case (state_q)
			S_LOAD: cmd.load_en = in_valid;
			S_RDA: cmd.m_addr = a_addr;
			S_RDB: begin
				cmd.opa_load = 1'b1;
				cmd.m_addr = b_addr;
				cmd.c_addr = b_addr;
			end
			S_MGO: cmd.mul_start = 1'b1;
			S_MWAIT: cmd.post = mi4_pkg::POST_NONE;
			S_POST: begin
				if (det_ph_q) begin
					cmd.post = (step_q == 4'd3) ? mi4_pkg::POST_DET : mi4_pkg::POST_NONE;
				end else begin
					cmd.post = st.post;
				end
			end
			S_ORD: begin
				cmd.m_addr = src_tr;
				cmd.c_addr = (run_mode_q == mi4_pkg::MODE_INV) ? src_tr : k_q;
			end
			S_OGO: begin
				cmd.res_load = 1'b1;
				cmd.div_start = need_div;
			end
			S_ODIV: cmd.post = mi4_pkg::POST_NONE;
			S_OPUT: cmd.out_load = sts.out_free;
			default: cmd.post = mi4_pkg::POST_NONE;
		endcase
	end

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q <= mi4_pkg::MODE_INV;
		end else if (cfg_valid) begin
			cfg_mode_q <= mi4_pkg::mode_t'(output_mode);
		end
	end

	// State machine and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			ld_cnt_q   <= 4'd0;
			k_q        <= 4'd0;
			step_q     <= 4'd0;
			det_ph_q   <= 1'b0;
			run_mode_q <= mi4_pkg::MODE_INV;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						ld_cnt_q <= 4'(ld_cnt_q + 4'd1);
						if (ld_cnt_q == 4'd15) begin
							run_mode_q <= cfg_mode_q;
							k_q        <= 4'd0;
							step_q     <= 4'd0;
							det_ph_q   <= 1'b0;
							state_q    <= S_RDA;
						end
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_MGO;
				S_MGO: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_RDA;
					if (det_ph_q) begin
						if (step_q == 4'd3) begin
							k_q     <= 4'd0;
							state_q <= S_ORD;
						end else begin
							step_q <= 4'(step_q + 4'd1);
						end
					end else if (step_q == 4'd8) begin
						step_q <= 4'd0;
						if (k_q == 4'd15) begin
							det_ph_q <= 1'b1;
						end else begin
							k_q <= 4'(k_q + 4'd1);
						end
					end else begin
						step_q <= 4'(step_q + 4'd1);
					end
				end
				S_ORD: state_q <= S_OGO;
				S_OGO: state_q <= need_div ? S_ODIV : S_OPUT;
				S_ODIV: begin
					if (sts.div_done) begin
						state_q <= S_OPUT;
					end
				end
				S_OPUT: begin
					if (sts.out_free) begin
						if (k_q == 4'd15) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= 4'(k_q + 4'd1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// The multiplier only reports a product while the controller waits for it.
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_MWAIT)
		else $error("multiplier finished outside its wait state");

	// The divider only reports a quotient while the controller waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_ODIV)
		else $error("divider finished outside its wait state");

	// The last result of a run returns the block to loading with an empty count.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OPUT && sts.out_free && k_q == 4'd15)
		|=> (state_q == S_LOAD && ld_cnt_q == 4'd0))
		else $error("run did not end cleanly");

	// The minor step counter stays within the nine products of a 3x3 determinant.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD && !det_ph_q) |-> step_q <= 4'd8)
		else $error("minor step out of range");

	// A beat is never offered to the output register while it still holds a stalled beat.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");

endmodule
